FILE: rtl/core/cylinder_wall_confinement_core_defines.svh
// assertion macros shared by the confinement core
`ifndef CYLINDER_WALL_CONFINEMENT_CORE_DEFINES_SVH
`define CYLINDER_WALL_CONFINEMENT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwc assertion failed");
`define CWC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwc assertion failed");
`else
`define CWC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CWC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/cwc_pkg.sv
package cwc_pkg;

    // register field widths
    localparam int RAD_W  = 31;
    localparam int HGT_W  = 31;
    localparam int SIZE_W = 10;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 2;

    // reset values
    localparam logic [RAD_W-1:0]  RADIUS_RST = 31'd655360;
    localparam logic [HGT_W-1:0]  HEIGHT_RST = 31'd1310720;
    localparam logic [SIZE_W-1:0] SIZE_RST   = 10'd1;

    // mirror band is 4L, hard reset point sits 2L inside the end
    localparam int MIRROR_SHIFT = 2;
    localparam int RESET_SHIFT  = 1;

    typedef enum logic [IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SIZE   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_MIRROR = 2'd1,
        ACT_RESET  = 2'd2
    } t_axial;

endpackage

FILE: rtl/core/cwc_isqrt.sv
module cwc_isqrt #(
    parameter int RW = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_rad,
    output logic [RW-1:0]   o_root
);

    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rest [RW];
    logic [RW+1:0]   n_rem  [RW];
    logic [RW-1:0]   n_root [RW];
    logic [2*RW-1:0] n_rest [RW];

    // one root bit per stage, two radicand bits brought down each time
    always_comb begin
        logic [RW+1:0]   rem_in;
        logic [RW+1:0]   t_sh;
        logic [RW+1:0]   trial;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] rest_in;
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rest_in = i_rad;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                rest_in = r_rest[k-1];
            end
            t_sh  = {rem_in[RW-1:0], rest_in[2*RW-1 -: 2]};
            trial = {root_in, 2'b01};
            if (t_sh >= trial) begin
                n_rem[k]  = t_sh - trial;
                n_root[k] = {root_in[RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = t_sh;
                n_root[k] = {root_in[RW-2:0], 1'b0};
            end
            n_rest[k] = rest_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rest[k] <= n_rest[k];
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

FILE: rtl/core/cwc_div.sv
module cwc_div #(
    parameter int DW = 32,
    parameter int QW = 31
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QW-1:0]    o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_low [QW];
    logic [QW-1:0] n_quo [QW];

    // restoring division, one quotient bit per stage; top part of the
    // numerator is already below the divisor
    always_comb begin
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   t_sh;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rem_in = i_num[DW+QW-1:QW];
                low_in = i_num[QW-1:0];
                quo_in = '0;
                den_in = i_den;
            end else begin
                rem_in = r_rem[k-1];
                low_in = r_low[k-1];
                quo_in = r_quo[k-1];
                den_in = r_den[k-1];
            end
            t_sh = {rem_in, low_in[QW-1]};
            if (t_sh >= {1'b0, den_in}) begin
                n_rem[k] = DW'(t_sh - {1'b0, den_in});
                n_quo[k] = {quo_in[QW-2:0], 1'b1};
            end else begin
                n_rem[k] = t_sh[DW-1:0];
                n_quo[k] = {quo_in[QW-2:0], 1'b0};
            end
            n_low[k] = low_in << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= (k == 0) ? i_den : r_den[k-1];
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

FILE: rtl/core/cylinder_wall_confinement_core.sv
// Confines one particle position per cycle, while the output does not stall,
// to a cylinder about the z axis. Points outside the radius are projected onto
// the wall through a pipelined square root (POS_WIDTH stages, one root bit
// each) and two pipelined dividers (31 stages, one quotient bit each); z is
// mirrored or reset near the end caps. A new item can be taken every cycle
// while no output waits. The whole pipeline holds while an output waits, so
// o_ready follows i_ready combinationally. Configuration writes take effect
// for derived values in the following cycle, as those are registered from the
// configuration registers, and must be made while the pipeline is empty.
`include "cylinder_wall_confinement_core_defines.svh"

module cylinder_wall_confinement_core
    import cwc_pkg::*;
#(
    parameter int POS_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [IDX_W-1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [POS_WIDTH-1:0] i_pos_x,
    input  logic signed [POS_WIDTH-1:0] i_pos_y,
    input  logic signed [POS_WIDTH-1:0] i_pos_z,
    input  logic                        i_last_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [POS_WIDTH-1:0] o_new_x,
    output logic signed [POS_WIDTH-1:0] o_new_y,
    output logic signed [POS_WIDTH-1:0] o_new_z,
    output logic                        o_radial_clipped,
    output logic [1:0]                  o_axial_action,
    output logic                        o_last_out
);

    localparam int ZW   = POS_WIDTH + FRAC_BITS + 16;
    localparam int SQW  = (2 * POS_WIDTH > 2 * RAD_W) ? 2 * POS_WIDTH : 2 * RAD_W;
    localparam int NUMW = POS_WIDTH + RAD_W;
    localparam int VW   = ((POS_WIDTH > RAD_W) ? POS_WIDTH : RAD_W) + 2;
    localparam int LAT  = 4 + POS_WIDTH + 1 + RAD_W;

    localparam logic signed [ZW-1:0] ZMAX =
        $signed({{(ZW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}});
    localparam logic signed [ZW-1:0] ZMIN = ~ZMAX;
    localparam logic signed [VW-1:0] VMAX =
        $signed({{(VW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}});
    localparam logic signed [VW-1:0] VMIN = ~VMAX;
    localparam logic [POS_WIDTH-1:0] PMAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic [POS_WIDTH-1:0] PMIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [POS_WIDTH-1:0]        mx;
        logic [POS_WIDTH-1:0]        my;
        logic signed [POS_WIDTH-1:0] x;
        logic signed [POS_WIDTH-1:0] y;
        logic signed [POS_WIDTH-1:0] z;
        t_axial                      act;
        logic                        clip;
        logic                        last;
    } t_side;

    // configuration registers
    logic [RAD_W-1:0]  r_radius;
    logic [HGT_W-1:0]  r_height;
    logic [SIZE_W-1:0] r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_height <= HEIGHT_RST;
            r_size   <= SIZE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                CFG_SIZE:   r_size   <= i_cfg_data[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    // values derived from configuration, static while items flow
    logic signed [ZW-1:0] w_unit;
    logic signed [ZW-1:0] w_half;
    logic signed [ZW-1:0] w_h;
    logic [2*RAD_W-1:0]   r_rad_sq;
    logic signed [ZW-1:0] r_hl;
    logic signed [ZW-1:0] r_lim4;
    logic signed [ZW-1:0] r_top_rst;
    logic signed [ZW-1:0] r_bot_rst;

    assign w_unit = $signed(ZW'(r_size)) <<< FRAC_BITS;
    assign w_half = $signed(ZW'(r_size)) <<< (FRAC_BITS - 1);
    assign w_h    = $signed(ZW'(r_height));

    always_ff @(posedge i_clk) begin
        r_rad_sq  <= {{RAD_W{1'b0}}, r_radius} * {{RAD_W{1'b0}}, r_radius};
        r_hl      <= w_h - w_half;
        r_lim4    <= w_unit <<< MIRROR_SHIFT;
        r_top_rst <= w_h - (w_unit <<< RESET_SHIFT);
        r_bot_rst <= (w_unit <<< RESET_SHIFT) - w_h;
    end

    // global advance: everything moves unless the output holds a waiting item
    logic           w_en;
    logic [LAT-1:0] r_vld;
    logic           r_ovld;

    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[LAT-2:0], i_valid};
            r_ovld <= r_vld[LAT-1];
        end
    end

    // stage 1: magnitudes and distances past each end
    logic [POS_WIDTH-1:0] w_mx;
    logic [POS_WIDTH-1:0] w_my;
    logic signed [ZW-1:0] w_z;
    t_side                r1_sd;
    logic signed [ZW-1:0] r1_z;
    logic signed [ZW-1:0] r1_dup;
    logic signed [ZW-1:0] r1_ddn;

    assign w_mx = i_pos_x[POS_WIDTH-1] ? POS_WIDTH'(-i_pos_x) : POS_WIDTH'(i_pos_x);
    assign w_my = i_pos_y[POS_WIDTH-1] ? POS_WIDTH'(-i_pos_y) : POS_WIDTH'(i_pos_y);
    assign w_z  = ZW'(i_pos_z);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sd.mx   <= w_mx;
            r1_sd.my   <= w_my;
            r1_sd.x    <= i_pos_x;
            r1_sd.y    <= i_pos_y;
            r1_sd.z    <= '0;
            r1_sd.act  <= ACT_NONE;
            r1_sd.clip <= 1'b0;
            r1_sd.last <= i_last_in;
            r1_z       <= w_z;
            r1_dup     <= w_z - r_hl;
            r1_ddn     <= -r_hl - w_z;
        end
    end

    // stage 2: squares, axial decision
    t_side                r2_sd;
    logic [2*POS_WIDTH-1:0] r2_sqx;
    logic [2*POS_WIDTH-1:0] r2_sqy;
    logic signed [ZW-1:0] r2_z;
    logic signed [ZW-1:0] n2_z;
    t_axial               n2_act;
    logic                 w_above;
    logic                 w_below;

    assign w_above = !r1_dup[ZW-1] && (r1_dup != '0);
    assign w_below = !r1_ddn[ZW-1] && (r1_ddn != '0);

    always_comb begin
        n2_z   = r1_z;
        n2_act = ACT_NONE;
        if (w_above) begin
            if (r1_dup > r_lim4) begin
                n2_z   = r_top_rst;
                n2_act = ACT_RESET;
            end else begin
                n2_z   = r_hl - r1_dup;
                n2_act = ACT_MIRROR;
            end
        end else if (w_below) begin
            if (r1_ddn > r_lim4) begin
                n2_z   = r_bot_rst;
                n2_act = ACT_RESET;
            end else begin
                n2_z   = r1_ddn - r_hl;
                n2_act = ACT_MIRROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sd     <= r1_sd;
            r2_sd.act <= n2_act;
            r2_sqx    <= {{POS_WIDTH{1'b0}}, r1_sd.mx} * {{POS_WIDTH{1'b0}}, r1_sd.mx};
            r2_sqy    <= {{POS_WIDTH{1'b0}}, r1_sd.my} * {{POS_WIDTH{1'b0}}, r1_sd.my};
            r2_z      <= n2_z;
        end
    end

    // stage 3: squared distance, z saturation
    t_side                  r3_sd;
    logic [2*POS_WIDTH-1:0] r3_s;
    logic [POS_WIDTH-1:0]   n3_z;

    always_comb begin
        if (r2_z > ZMAX) begin
            n3_z = PMAX;
        end else if (r2_z < ZMIN) begin
            n3_z = PMIN;
        end else begin
            n3_z = r2_z[POS_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sd   <= r2_sd;
            r3_sd.z <= n3_z;
            r3_s    <= r2_sqx + r2_sqy;
        end
    end

    // stage 4: outside-wall test
    t_side                  r4_sd;
    logic [2*POS_WIDTH-1:0] r4_s;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sd      <= r3_sd;
            r4_sd.clip <= SQW'(r3_s) > SQW'(r_rad_sq);
            r4_s       <= r3_s;
        end
    end

    // distance from the axis
    logic [POS_WIDTH-1:0] w_root;

    cwc_isqrt #(
        .RW (POS_WIDTH)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_s),
        .o_root (w_root)
    );

    // side data follows the root pipeline
    t_side r_sda [POS_WIDTH];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < POS_WIDTH; k++) begin
                r_sda[k] <= (k == 0) ? r4_sd : r_sda[k-1];
            end
        end
    end

    // scale magnitudes by the radius
    t_side                r_msd;
    logic [NUMW-1:0]      r_px;
    logic [NUMW-1:0]      r_py;
    logic [POS_WIDTH-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_msd <= r_sda[POS_WIDTH-1];
            r_px  <= NUMW'(r_sda[POS_WIDTH-1].mx) * NUMW'(r_radius);
            r_py  <= NUMW'(r_sda[POS_WIDTH-1].my) * NUMW'(r_radius);
            r_den <= w_root;
        end
    end

    logic [RAD_W-1:0] w_qx;
    logic [RAD_W-1:0] w_qy;

    cwc_div #(
        .DW (POS_WIDTH),
        .QW (RAD_W)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_px),
        .i_den (r_den),
        .o_quo (w_qx)
    );

    cwc_div #(
        .DW (POS_WIDTH),
        .QW (RAD_W)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_py),
        .i_den (r_den),
        .o_quo (w_qy)
    );

    // side data follows the divider pipeline
    t_side r_sdb [RAD_W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < RAD_W; k++) begin
                r_sdb[k] <= (k == 0) ? r_msd : r_sdb[k-1];
            end
        end
    end

    // clamp to the radius, restore sign, saturate
    function automatic logic signed [POS_WIDTH-1:0] f_wall(
        input logic [RAD_W-1:0] q,
        input logic             neg,
        input logic [RAD_W-1:0] rad
    );
        logic [RAD_W-1:0]     qc;
        logic signed [VW-1:0] v;
        qc = (q > rad) ? rad : q;
        v  = neg ? -$signed(VW'(qc)) : $signed(VW'(qc));
        if (v > VMAX) begin
            v = VMAX;
        end else if (v < VMIN) begin
            v = VMIN;
        end
        return v[POS_WIDTH-1:0];
    endfunction

    t_side                       w_fsd;
    logic signed [POS_WIDTH-1:0] r_new_x;
    logic signed [POS_WIDTH-1:0] r_new_y;
    logic signed [POS_WIDTH-1:0] r_new_z;
    logic                        r_clip;
    t_axial                      r_act;
    logic                        r_last;

    assign w_fsd = r_sdb[RAD_W-1];

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_new_x <= w_fsd.clip ? f_wall(w_qx, w_fsd.x[POS_WIDTH-1], r_radius) : w_fsd.x;
            r_new_y <= w_fsd.clip ? f_wall(w_qy, w_fsd.y[POS_WIDTH-1], r_radius) : w_fsd.y;
            r_new_z <= w_fsd.z;
            r_clip  <= w_fsd.clip;
            r_act   <= w_fsd.act;
            r_last  <= w_fsd.last;
        end
    end

    assign o_new_x          = r_new_x;
    assign o_new_y          = r_new_y;
    assign o_new_z          = r_new_z;
    assign o_radial_clipped = r_clip;
    assign o_axial_action   = r_act;
    assign o_last_out       = r_last;

    // magnitude of x on a clipped result, for the wall check
    logic [POS_WIDTH:0] w_ax;
    logic               w_in_wall;

    assign w_ax      = o_new_x[POS_WIDTH-1] ? ((POS_WIDTH+1)'(0) - {1'b1, o_new_x})
                                            : {1'b0, o_new_x};
    assign w_in_wall = VW'(w_ax) <= VW'(r_radius);

    `CWC_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_vld[0])
    `CWC_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(r_vld))
    `CWC_ASSERT_IMP(a_on_wall, i_clk, i_rst_n, o_valid && o_radial_clipped, w_in_wall)

endmodule

FILE: tb/cylinder_wall_confinement_checker.sv
module cylinder_wall_confinement_checker
    import cwc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_last_in,
    input  logic               i_out_valid,
    input  logic               i_ready,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic signed [31:0] i_new_z,
    input  logic               i_radial_clipped,
    input  logic [1:0]         i_axial_action,
    input  logic               i_last_out,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               clipped;
        t_axial             action;
        logic               last;
    } t_confined;

    t_confined confined_q[$];

    // shadow copy of the registers
    logic [RAD_W-1:0]  radius;
    logic [HGT_W-1:0]  height;
    logic [SIZE_W-1:0] psize;

    // saturate to 32-bit signed
    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // floor of the square root of a 64-bit value
    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned c;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if (c * c <= s) res = c;
        end
        return res;
    endfunction

    // pull one coordinate onto the wall along its own direction
    function automatic longint wall_point(longint c, longint unsigned r);
        longint unsigned q;
        longint unsigned m;
        m = (c < 0) ? -c : c;
        q = (m * radius) / r;
        if (q > radius) q = radius;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_confined confine(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz, logic lst);
        t_confined res;
        longint x, y, z, unit, h, hl, d;
        longint unsigned s, r2, r;
        x = px;
        y = py;
        z = pz;
        unit = longint'(psize) << 16;
        h = height;
        hl = h - (longint'(psize) << 15);
        s = longint'(x * x) + longint'(y * y);
        r2 = longint'(radius) * longint'(radius);
        res.clipped = 1'b0;
        res.action = ACT_NONE;
        // radial projection
        if (s > r2) begin
            r = isqrt(s);
            if (r == 0) r = 1;
            x = wall_point(x, r);
            y = wall_point(y, r);
            res.clipped = 1'b1;
        end
        // axial end caps, upper test first
        if (z > hl) begin
            d = z - hl;
            if (d > 4 * unit) begin
                z = h - 2 * unit;
                res.action = ACT_RESET;
            end else begin
                z = hl - d;
                res.action = ACT_MIRROR;
            end
        end else if (z < -hl) begin
            d = -hl - z;
            if (d > 4 * unit) begin
                z = 2 * unit - h;
                res.action = ACT_RESET;
            end else begin
                z = -hl + d;
                res.action = ACT_MIRROR;
            end
        end
        res.x = clamp32(x);
        res.y = clamp32(y);
        res.z = clamp32(z);
        res.last = lst;
        return res;
    endfunction

    // track register writes, predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        t_confined exp_res;
        if (!i_rst_n) begin
            radius <= RADIUS_RST;
            height <= HGT_W'(HEIGHT_RST);
            psize <= SIZE_RST;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS: radius <= i_cfg_data[RAD_W-1:0];
                    CFG_HEIGHT: height <= i_cfg_data[HGT_W-1:0];
                    CFG_SIZE:   psize <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && i_in_ready)
                confined_q.push_back(confine(i_pos_x, i_pos_y, i_pos_z, i_last_in));
            if (i_out_valid && i_ready) begin
                if (confined_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                             i_new_x, i_new_y, i_new_z);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = confined_q.pop_front();
                    if (exp_res.x !== i_new_x || exp_res.y !== i_new_y ||
                        exp_res.z !== i_new_z || exp_res.clipped !== i_radial_clipped ||
                        exp_res.action !== i_axial_action || exp_res.last !== i_last_out) begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d clip=%0b act=%0d last=%0b",
                                 $time, exp_res.x, exp_res.y, exp_res.z, exp_res.clipped,
                                 exp_res.action, exp_res.last);
                        $display("%0t:          actual x=%0d y=%0d z=%0d clip=%0b act=%0d last=%0b",
                                 $time, i_new_x, i_new_y, i_new_z, i_radial_clipped,
                                 i_axial_action, i_last_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        // results still owed by the block
        o_pending <= confined_q.size();
    end

endmodule

FILE: tb/cylinder_wall_confinement_core_test.sv
module cylinder_wall_confinement_core_test;
    import cwc_pkg::*;

    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT = 80;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic               i_last_in;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_new_x;
    logic signed [31:0] o_new_y;
    logic signed [31:0] o_new_z;
    logic               o_radial_clipped;
    logic [1:0]         o_axial_action;
    logic               o_last_out;

    int fail_count;
    int pending;
    int cycles;
    int idle_pct;
    int stall_pct;
    bit hold_req;

    // current register values, used to aim stimulus at the interesting regions
    longint cur_radius;
    longint cur_height;
    longint cur_size;

    cylinder_wall_confinement_core dut (.*);

    cylinder_wall_confinement_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(i_valid), .i_in_ready(o_ready),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z), .i_last_in(i_last_in),
        .i_out_valid(o_valid), .i_ready(i_ready), .i_new_x(o_new_x), .i_new_y(o_new_y),
        .i_new_z(o_new_z), .i_radial_clipped(o_radial_clipped),
        .i_axial_action(o_axial_action), .i_last_out(o_last_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (int n = 0; n < 400; n++) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RADIUS: cur_radius = data;
            CFG_HEIGHT: cur_height = data;
            CFG_SIZE:   cur_size = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // offer one particle and wait for its transfer
    task automatic send(logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [31:0] z, logic lst);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_last_in <= lst;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // let the pipeline empty before touching registers
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] sat(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // radial coordinate: full range, extremes, or near the wall
    function automatic logic signed [31:0] pick_radial();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return sat(($urandom_range(1) ? 1 : -1) *
                                ((cur_radius * $urandom_range(150)) / 100 +
                                 $urandom_range(3) - 1));
        endcase
    endfunction

    // axial coordinate: full range, or around either end cap within a few sizes
    function automatic logic signed [31:0] pick_axial();
        longint lim;
        longint off;
        lim = cur_height - (cur_size << 15);
        off = ((cur_size << 16) * $urandom_range(600)) / 100 + $urandom_range(3) - 1;
        case ($urandom_range(4))
            0: return $urandom;
            1: return sat(lim - off);
            2: return sat(lim + off);
            3: return sat(-lim + off);
            default: return sat(-lim - off);
        endcase
    endfunction

    task automatic run_directed();
        longint lim;
        longint band;
        lim = cur_height - (cur_size << 15);
        band = 4 * (cur_size << 16);
        send(0, 0, 0, 1'b0);
        send(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
        send(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
        send(32'sh80000000, 0, 32'sh7fffffff, 1'b1);
        send(0, 32'sh7fffffff, 32'sh80000000, 1'b0);
        send(sat(cur_radius), 0, sat(lim), 1'b0);
        send(sat(cur_radius + 1), 0, sat(lim + 1), 1'b0);
        send(0, sat(-cur_radius - 1), sat(-lim), 1'b0);
        send(sat(cur_radius), sat(cur_radius), sat(-lim - 1), 1'b1);
        send(3, -4, sat(lim + band), 1'b0);
        send(-3, 4, sat(lim + band + 1), 1'b0);
        send(1, 1, sat(-lim - band), 1'b0);
        send(1, -1, sat(-lim - band - 1), 1'b1);
        send(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 1'b0);
        send(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 1'b1);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
            send(pick_radial(), pick_radial(), pick_axial(), $urandom_range(1));
    endtask

    // stimulus
    initial begin
        hold_req = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        cur_radius = RADIUS_RST;
        cur_height = HEIGHT_RST;
        cur_size = SIZE_RST;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_RADIUS;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_pos_z <= '0;
        i_last_in <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, no idling
        run_directed();
        run_random(60);

        // block fills while the receiver holds off
        hold_req = 1'b1;
        run_random(120);
        drain();

        // largest settings, sender idles a lot
        write_reg(CFG_RADIUS, 31'h7fffffff);
        write_reg(CFG_HEIGHT, 31'h7fffffff);
        write_reg(CFG_SIZE, 31'd1023);
        write_reg(CFG_SPARE, 31'h12345);
        @(posedge i_clk);
        idle_pct = 77;
        run_directed();
        run_random(80);
        drain();

        // zero settings, receiver stalls a lot
        write_reg(CFG_RADIUS, 31'd0);
        write_reg(CFG_HEIGHT, 31'd0);
        write_reg(CFG_SIZE, 31'd0);
        @(posedge i_clk);
        idle_pct = 0;
        stall_pct = 77;
        run_directed();
        run_random(80);
        drain();

        // end limit below zero: height smaller than half the size
        write_reg(CFG_RADIUS, 31'd3 << 16);
        write_reg(CFG_HEIGHT, 31'd100 << 16);
        write_reg(CFG_SIZE, 31'd700);
        @(posedge i_clk);
        idle_pct = 36;
        stall_pct = 36;
        run_directed();
        run_random(80);
        drain();

        // random settings, cycling through the idling mixes
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_RADIUS,
                      CFG_W'($urandom_range(32'h7fffffff >> (4 * $urandom_range(7)))));
            write_reg(CFG_HEIGHT,
                      CFG_W'($urandom_range(32'h7fffffff >> (4 * $urandom_range(7)))));
            write_reg(CFG_SIZE, CFG_W'($urandom_range(1023 >> $urandom_range(9))));
            @(posedge i_clk);
            idle_pct = (p == 1 || p == 3) ? 77 : 0;
            stall_pct = (p >= 2) ? 77 : 0;
            if (p == 3) begin
                idle_pct = 36;
                stall_pct = 36;
            end
            run_random(50);
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
